>>> hw/rtl/dqd_pkg.sv
// Package for the double-ended queue with delete by value.
// Holds the depth, derived widths, command and status codes and ring helpers.
// Depends on nothing.
`default_nettype none

package dqd_pkg;

   localparam int DEPTH  = 128;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;
   localparam int OCNT_W = 8;
   localparam int IDX_W  = ((ADDR_W > POS_W) ? ADDR_W : POS_W) + 1;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_DELETE     = 2'd2,
      CMD_READ       = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   function automatic addr_type ring_next(input addr_type i);
      return (i == addr_type'(DEPTH - 1)) ? '0 : addr_type'(i + 1'b1);
   endfunction

   function automatic addr_type ring_prev(input addr_type i);
      return (i == '0) ? addr_type'(DEPTH - 1) : addr_type'(i - 1'b1);
   endfunction

   // Wraps a sum known to stay below twice the depth.
   function automatic addr_type ring_wrap(input logic [IDX_W-1:0] s);
      logic [IDX_W-1:0] r;
      r = (s >= IDX_W'(DEPTH)) ? IDX_W'(s - IDX_W'(DEPTH)) : s;
      return r[ADDR_W-1:0];
   endfunction

   function automatic logic [OCNT_W-1:0] count_field(input cnt_type c);
      logic [CNT_W+OCNT_W-1:0] t;
      t = {{OCNT_W{1'b0}}, c};
      return t[OCNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dqd_req_if.sv
// Command channel of the queue: valid, ready and one command beat.
// Depends on dqd_pkg for the field widths.
`default_nettype none

interface dqd_req_if
   import dqd_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               cmd;
   logic signed [DATA_W-1:0] value;
   logic [POS_W-1:0]         position;

   modport source (output valid, cmd, value, position, input ready);
   modport sink   (input valid, cmd, value, position, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dqd_rsp_if.sv
// Result channel of the queue: valid, ready and one result beat.
// Depends on dqd_pkg for the field widths.
`default_nettype none

interface dqd_rsp_if
   import dqd_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic signed [DATA_W-1:0] data_out;
   logic [OCNT_W-1:0]        count;
   logic                     is_empty;
   logic                     is_full;

   modport source (output valid, status, data_out, count, is_empty, is_full, input ready);
   modport sink   (input valid, status, data_out, count, is_empty, is_full, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/deque_with_delete_by_value.sv
// Double-ended queue of signed 32-bit words held in a ring in one RAM.
// Commands arrive on req: push front, push back, delete the first entry equal
// to a value, or read the entry at a position counted from the front. Every
// command beat returns exactly one result beat on rsp with a status, a data
// word, the entry count after the command and empty and full flags.
// A command is accepted whenever the controller is idle, even while the
// previous result still waits on rsp; it is then finished and held until the
// rsp register is free. A push writes the RAM in S_EXEC and a read waits in
// S_RD_WAIT for the registered RAM data; both then pass S_EMIT to the result
// register. The controller takes the next command only when back in idle, so
// a new command is not taken before the last result is registered. A delete
// scans from the front with one RAM read and one compare per entry and then
// moves each later entry one place toward the front with one read and one
// write; the single registered read port of the storage RAM sets this order.
// Reset clears the pointers, the count and both handshakes; the storage is
// not cleared and is read only at entries that were written. A stalled rsp
// keeps its beat unchanged and holds the next result and req in S_EMIT.
// Depends on dqd_pkg, dqd_req_if, dqd_rsp_if and dqd_ram.
`default_nettype none

module deque_with_delete_by_value
   import dqd_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   dqd_req_if.sink  req,
   dqd_rsp_if.source rsp
);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_RD_WAIT, S_SRCH_RD, S_SRCH_CMP, S_SH_RD, S_SH_WR, S_EMIT
   } state_type;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [DATA_W-1:0]      value_ff, value_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   addr_type               head_ff, head_in;
   addr_type               tail_ff, tail_in;
   cnt_type                count_ff, count_in;
   addr_type               idx_ff, idx_in;
   cnt_type                k_ff, k_in;
   status_type             res_status_ff, res_status_in;
   logic [DATA_W-1:0]      res_data_ff, res_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [OCNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                   rsp_empty_ff, rsp_empty_in;
   logic                   rsp_full_ff, rsp_full_in;

   logic                   mem_we;
   addr_type               mem_waddr, mem_raddr;
   logic [DATA_W-1:0]      mem_wdata, mem_rdata;

   logic                   is_empty, is_full;
   cnt_type                k_next;
   logic [IDX_W-1:0]       pos_sum, tail_sum;

   dqd_ram #(
      .WIDTH(DATA_W), .DEPTH_P(DEPTH), .AW(ADDR_W)
   ) u_ram (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(mem_wdata),
      .rd_addr(mem_raddr), .rd_data(mem_rdata)
   );

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == cnt_type'(DEPTH));
   assign k_next   = cnt_type'(k_ff + 1'b1);
   assign pos_sum  = IDX_W'(head_ff) + IDX_W'(pos_ff);
   assign tail_sum = IDX_W'(IDX_W'(head_ff) + IDX_W'(count_ff) - 1'b1);

   assign req.ready    = (state_ff == S_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.status   = rsp_status_ff;
   assign rsp.data_out = rsp_data_ff;
   assign rsp.count    = rsp_count_ff;
   assign rsp.is_empty = rsp_empty_ff;
   assign rsp.is_full  = rsp_full_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = value_ff;
      mem_raddr     = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in   = cmd_type'(req.cmd);
               value_in = req.value;
               pos_in   = req.position;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_data_in = '0;
            res_status_in = ST_OK;
            state_in = S_EMIT;
            unique case (cmd_ff)
               CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                  if (is_full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     mem_we = 1'b1;
                     if (is_empty) begin
                        head_in = '0;
                        tail_in = '0;
                     end else if (cmd_ff == CMD_PUSH_FRONT) begin
                        head_in = ring_prev(head_ff);
                     end else begin
                        tail_in = ring_next(tail_ff);
                     end
                     mem_waddr = (cmd_ff == CMD_PUSH_FRONT) ? head_in : tail_in;
                     count_in = cnt_type'(count_ff + 1'b1);
                  end
               end
               CMD_DELETE: begin
                  if (is_empty) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     idx_in   = head_ff;
                     k_in     = '0;
                     state_in = S_SRCH_RD;
                  end
               end
               CMD_READ: begin
                  mem_raddr = ring_wrap(pos_sum);
                  if (is_empty) begin
                     res_status_in = ST_EMPTY;
                  end else if (IDX_W'(pos_ff) >= IDX_W'(count_ff)) begin
                     res_status_in = ST_MISS;
                  end else begin
                     state_in = S_RD_WAIT;
                  end
               end
               default: state_in = S_EMIT;
            endcase
         end
         S_RD_WAIT: begin
            res_data_in = mem_rdata;
            state_in    = S_EMIT;
         end
         S_SRCH_RD: begin
            state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (mem_rdata == value_ff) begin
               if (k_next < count_ff) begin
                  k_in     = k_next;
                  state_in = S_SH_RD;
               end else begin
                  tail_in     = ring_prev(tail_ff);
                  count_in    = cnt_type'(count_ff - 1'b1);
                  res_data_in = value_ff;
                  state_in    = S_EMIT;
               end
            end else if (k_next == count_ff) begin
               res_status_in = ST_MISS;
               state_in      = S_EMIT;
            end else begin
               idx_in   = ring_next(idx_ff);
               k_in     = k_next;
               state_in = S_SRCH_RD;
            end
         end
         S_SH_RD: begin
            mem_raddr = ring_next(idx_ff);
            state_in  = S_SH_WR;
         end
         S_SH_WR: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
            idx_in    = ring_next(idx_ff);
            k_in      = k_next;
            if (k_next < count_ff) begin
               state_in = S_SH_RD;
            end else begin
               tail_in     = ring_prev(tail_ff);
               count_in    = cnt_type'(count_ff - 1'b1);
               res_data_in = value_ff;
               state_in    = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = res_data_ff;
               rsp_count_in  = count_field(count_ff);
               rsp_empty_in  = is_empty;
               rsp_full_in   = is_full;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(DEPTH))
      else $error("entry count exceeds the depth");

   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (ring_wrap(tail_sum) == tail_ff))
      else $error("head, tail and count disagree");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH_RD || state_ff == S_SRCH_CMP || state_ff == S_SH_RD ||
       state_ff == S_SH_WR) |-> (k_ff < count_ff))
      else $error("scan index ran past the entries held");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == S_EXEC && (cmd_ff == CMD_PUSH_FRONT ||
                   cmd_ff == CMD_PUSH_BACK)) || state_ff == S_SH_WR))
      else $error("storage written outside a push or a shift");

endmodule

`default_nettype wire

>>> hw/rtl/dqd_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// Self-contained; used as the entry storage of the queue.
`default_nettype none

module dqd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH_P = 128,
   parameter int AW = 7
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH_P];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
